// ===== rtl/tank_level_hysteresis_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// tank level controller assertion macros
// clocked property wrappers that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef TANK_LEVEL_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH
`define TANK_LEVEL_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TLHC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlhc assertion failed");

// next-cycle implication
`define TLHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlhc assertion failed");

`else

`define TLHC_ASSERT_NOW(lbl, ante, cons)
`define TLHC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/tlhc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlhc_pkg
// shared types and constants of the tank level hysteresis controller
// ----------------------------------------------------------------------------
package tlhc_pkg;

    // field widths
    localparam int LEVEL_W = 12;
    localparam int PCT_W   = 7;
    localparam int CODE_W  = 2;
    localparam int CFG_IDX_W = 3;

    // shared divider sizing
    localparam int QUO_W     = 12;
    localparam int STEP_W    = 4;
    localparam int AVG_STEPS = 12;
    localparam int PCT_STEPS = 7;
    localparam int PCT_SHIFT = PCT_STEPS - 1;
    localparam int DIV_MIN_W = 19;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

    // default parameter values
    localparam int AVG_COUNT_DEF   = 100;
    localparam int SAMPLE_BITS_DEF = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_DEADBAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_MARGIN   = 3'd4;

    // register reset values
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST      = 12'd2165;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST      = 12'd2722;
    localparam logic [LEVEL_W-1:0] TREND_DEADBAND_RST = 12'd12;
    localparam logic [LEVEL_W-1:0] MANUAL_LIMIT_RST   = 12'd3093;
    localparam logic [LEVEL_W-1:0] CLASS_MARGIN_RST   = 12'd62;

    // trend codes
    localparam logic [CODE_W-1:0] TREND_STEADY  = 2'd0;
    localparam logic [CODE_W-1:0] TREND_RISING  = 2'd1;
    localparam logic [CODE_W-1:0] TREND_FALLING = 2'd2;

    // level class codes
    localparam logic [CODE_W-1:0] CLASS_LOW    = 2'd0;
    localparam logic [CODE_W-1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [CODE_W-1:0] CLASS_FULL   = 2'd2;

    // led state codes, bit 0 green, bit 1 red
    localparam logic [1:0] LED_OFF   = 2'b00;
    localparam logic [1:0] LED_GREEN = 2'b01;
    localparam logic [1:0] LED_RED   = 2'b10;
    localparam logic [1:0] LED_BOTH  = 2'b11;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_START,
        S_AVG_WAIT,
        S_CTRL,
        S_PCT_START,
        S_PCT_WAIT,
        S_EMIT
    } state_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

// ===== rtl/tank_level_hysteresis_controller_core.sv =====
// A sample that does not close a window is only added to the sum, and such samples are
// accepted back to back. A window-closing sample runs the average division, control and,
// when the average lies strictly inside the span, the percent division; a toggle runs
// control and, when needed, the percent division. Both divisions share one restoring
// divider, one bit per cycle, and block input until the result is emitted, also under output stalls.
// Reset (async, low) clears thresholds to defaults, sums, pump, LEDs, alerts.
// ----------------------------------------------------------------------------
// tank_level_hysteresis_controller_core
// averages level windows and drives a two-threshold pump control with
// trend, class and fill-percent reporting
// ----------------------------------------------------------------------------
`include "tank_level_hysteresis_controller_core_assert.svh"

module tank_level_hysteresis_controller_core
    import tlhc_pkg::*;
#(
    parameter int AVG_COUNT   = AVG_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [LEVEL_W-1:0]   sample,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 pump_on,
    output logic                 green_led,
    output logic                 red_led,
    output logic                 alert_full,
    output logic                 alert_empty,
    output logic [CODE_W-1:0]    trend,
    output logic [CODE_W-1:0]    level_class,
    output logic [PCT_W-1:0]     fill_percent,
    output logic [LEVEL_W-1:0]   average_code
);

    localparam int SAMPLE_W = (SAMPLE_BITS < LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int CNT_W    = $clog2(AVG_COUNT + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int DIV_W    = (SUM_W > DIV_MIN_W) ? SUM_W : DIV_MIN_W;
    localparam logic [LEVEL_W-1:0] SAMPLE_MASK = LEVEL_W'((32'd1 << SAMPLE_W) - 32'd1);
    localparam logic [DIV_W-1:0]   AVG_DIVISOR = DIV_W'(AVG_COUNT) << (AVG_STEPS - 1);

    // configuration registers
    logic [LEVEL_W-1:0] min_level_reg;
    logic [LEVEL_W-1:0] max_level_reg;
    logic [LEVEL_W-1:0] trend_deadband_reg;
    logic [LEVEL_W-1:0] manual_limit_reg;
    logic [LEVEL_W-1:0] class_margin_reg;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEVEL_W-1:0] last_avg_reg;
    logic               pump_reg;
    logic [1:0]         led_reg;
    logic               full_alerted_reg;
    logic               empty_alerted_reg;
    logic               toggle_reg;

    // working registers
    logic [LEVEL_W-1:0] avg_reg;
    logic               af_reg;
    logic               ae_reg;
    logic [CODE_W-1:0]  tr_reg;
    logic [CODE_W-1:0]  cls_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   den_reg;

    // output registers
    logic               out_valid_reg;
    logic               pump_out_reg;
    logic               green_out_reg;
    logic               red_out_reg;
    logic               af_out_reg;
    logic               ae_out_reg;
    logic [CODE_W-1:0]  tr_out_reg;
    logic [CODE_W-1:0]  cls_out_reg;
    logic [PCT_W-1:0]   pct_out_reg;
    logic [LEVEL_W-1:0] avg_out_reg;

    // shared divider
    div_req_t           div_req;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;

    // handshake and helpers
    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_inc;
    logic               win_end;
    logic               ctrl_need_div;
    logic [PCT_W-1:0]   ctrl_pct;
    logic [CODE_W-1:0]  ctrl_cls;
    logic [CODE_W-1:0]  ctrl_tr;
    logic signed [LEVEL_W+1:0] full_th;
    logic signed [LEVEL_W+1:0] low_th;
    logic signed [LEVEL_W+1:0] avg_s;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign in_stall = (state_reg != S_IDLE);

    // window accumulation
    assign sum_add = sum_reg + SUM_W'(sample & SAMPLE_MASK);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign win_end = (cnt_inc == CNT_W'(AVG_COUNT));

    // class thresholds, signed so they never wrap
    assign full_th = $signed({2'b00, max_level_reg}) - $signed({2'b00, class_margin_reg});
    assign low_th  = $signed({2'b00, min_level_reg}) + $signed({2'b00, class_margin_reg});
    assign avg_s   = $signed({2'b00, avg_reg});

    always_comb
    begin
        if (avg_s >= full_th)
        begin
            ctrl_cls = CLASS_FULL;
        end
        else if (avg_s <= low_th)
        begin
            ctrl_cls = CLASS_LOW;
        end
        else
        begin
            ctrl_cls = CLASS_MEDIUM;
        end
    end

    // trend against the previous average
    always_comb
    begin
        if (avg_reg > last_avg_reg && (avg_reg - last_avg_reg) > trend_deadband_reg)
        begin
            ctrl_tr = TREND_RISING;
        end
        else if (last_avg_reg > avg_reg && (last_avg_reg - avg_reg) > trend_deadband_reg)
        begin
            ctrl_tr = TREND_FALLING;
        end
        else
        begin
            ctrl_tr = TREND_STEADY;
        end
    end

    // fill percent end cases, division needed only strictly inside the span
    always_comb
    begin
        ctrl_need_div = 1'b0;
        if (max_level_reg <= min_level_reg)
        begin
            ctrl_pct = (avg_reg >= max_level_reg) ? PCT_FULL : PCT_ZERO;
        end
        else if (avg_reg <= min_level_reg)
        begin
            ctrl_pct = PCT_ZERO;
        end
        else if (avg_reg >= max_level_reg)
        begin
            ctrl_pct = PCT_FULL;
        end
        else
        begin
            ctrl_pct      = PCT_ZERO;
            ctrl_need_div = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (func)
                    begin
                        state_next = S_CTRL;
                    end
                    else if (win_end)
                    begin
                        state_next = S_AVG_START;
                    end
                end
            end
            S_AVG_START:
            begin
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_CTRL;
                end
            end
            S_CTRL:
            begin
                state_next = ctrl_need_div ? S_PCT_START : S_EMIT;
            end
            S_PCT_START:
            begin
                state_next = S_PCT_WAIT;
            end
            S_PCT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // divider requests
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(AVG_STEPS);
        div_dividend  = DIV_W'(sum_reg);
        div_divisor   = AVG_DIVISOR;
        unique case (state_reg)
            S_AVG_START:
            begin
                div_req.start = 1'b1;
            end
            S_PCT_START:
            begin
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(PCT_STEPS);
                div_dividend  = num_reg;
                div_divisor   = den_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    tlhc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg      <= MIN_LEVEL_RST;
            max_level_reg      <= MAX_LEVEL_RST;
            trend_deadband_reg <= TREND_DEADBAND_RST;
            manual_limit_reg   <= MANUAL_LIMIT_RST;
            class_margin_reg   <= CLASS_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_LEVEL:      min_level_reg      <= cfg_data;
                REG_MAX_LEVEL:      max_level_reg      <= cfg_data;
                REG_TREND_DEADBAND: trend_deadband_reg <= cfg_data;
                REG_MANUAL_LIMIT:   manual_limit_reg   <= cfg_data;
                REG_CLASS_MARGIN:   class_margin_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            last_avg_reg      <= '0;
            pump_reg          <= 1'b0;
            led_reg           <= LED_OFF;
            full_alerted_reg  <= 1'b0;
            empty_alerted_reg <= 1'b0;
            toggle_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        toggle_reg <= func;
                        if (func)
                        begin
                            if (last_avg_reg < manual_limit_reg)
                            begin
                                pump_reg <= !pump_reg;
                            end
                        end
                        else
                        begin
                            sum_reg <= sum_add;
                            cnt_reg <= win_end ? '0 : cnt_inc;
                        end
                    end
                end
                S_AVG_START:
                begin
                    sum_reg <= '0;
                end
                S_CTRL:
                begin
                    // hysteresis control on a closed window
                    if (!toggle_reg)
                    begin
                        last_avg_reg <= avg_reg;
                        if (avg_reg >= max_level_reg)
                        begin
                            pump_reg <= 1'b0;
                            led_reg  <= LED_GREEN;
                            if (!full_alerted_reg)
                            begin
                                full_alerted_reg  <= 1'b1;
                                empty_alerted_reg <= 1'b0;
                            end
                        end
                        else if (avg_reg <= min_level_reg)
                        begin
                            pump_reg <= 1'b1;
                            led_reg  <= LED_RED;
                            if (!empty_alerted_reg)
                            begin
                                empty_alerted_reg <= 1'b1;
                                full_alerted_reg  <= 1'b0;
                            end
                        end
                        else
                        begin
                            led_reg <= LED_BOTH;
                        end
                    end
                end
                default:
                begin
                    toggle_reg <= toggle_reg;
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_xfer && func)
        begin
            avg_reg <= last_avg_reg;
        end
        else if (state_reg == S_AVG_WAIT && div_done)
        begin
            avg_reg <= div_quo[LEVEL_W-1:0];
        end

        if (state_reg == S_CTRL)
        begin
            af_reg  <= !toggle_reg && (avg_reg >= max_level_reg) && !full_alerted_reg;
            ae_reg  <= !toggle_reg && (avg_reg < max_level_reg)
                       && (avg_reg <= min_level_reg) && !empty_alerted_reg;
            tr_reg  <= toggle_reg ? TREND_STEADY : ctrl_tr;
            cls_reg <= ctrl_cls;
            pct_reg <= ctrl_pct;
            num_reg <= DIV_W'(avg_reg - min_level_reg) * DIV_W'(PCT_FULL);
            den_reg <= DIV_W'(max_level_reg - min_level_reg) << PCT_SHIFT;
        end
        else if (state_reg == S_PCT_WAIT && div_done)
        begin
            pct_reg <= div_quo[PCT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pump_out_reg  <= pump_reg;
            green_out_reg <= led_reg[0];
            red_out_reg   <= led_reg[1];
            af_out_reg    <= af_reg;
            ae_out_reg    <= ae_reg;
            tr_out_reg    <= tr_reg;
            cls_out_reg   <= cls_reg;
            pct_out_reg   <= pct_reg;
            avg_out_reg   <= avg_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pump_on      = pump_out_reg;
    assign green_led    = green_out_reg;
    assign red_led      = red_out_reg;
    assign alert_full   = af_out_reg;
    assign alert_empty  = ae_out_reg;
    assign trend        = tr_out_reg;
    assign level_class  = cls_out_reg;
    assign fill_percent = pct_out_reg;
    assign average_code = avg_out_reg;

    // checks
    `TLHC_ASSERT_NOW(a_pct_range, out_valid_reg, pct_out_reg <= PCT_FULL)
    `TLHC_ASSERT_NOW(a_alert_excl, out_valid_reg, !(af_out_reg && ae_out_reg))
    `TLHC_ASSERT_NOW(a_div_owner, div_done,
        (state_reg == S_AVG_WAIT) || (state_reg == S_PCT_WAIT))
    `TLHC_ASSERT_NEXT(a_toggle_runs, (state_reg == S_IDLE) && in_xfer && func,
        state_reg == S_CTRL)

endmodule

// ===== rtl/tlhc_div.sv =====
// ----------------------------------------------------------------------------
// tlhc_div
// restoring divider, one quotient bit per cycle; the divisor arrives
// pre-aligned to the top quotient bit and the step count sets the bits
// ----------------------------------------------------------------------------
module tlhc_div
    import tlhc_pkg::*;
#(
    parameter int DIV_W = DIV_MIN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic              fits;

    // one compare and subtract per step
    assign fits = (rem_reg >= dsh_reg);

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= req.steps;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - STEP_W'(1);
                done_reg <= (cnt_reg == STEP_W'(1));
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= dividend;
            dsh_reg <= divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
